/* hw/rtl/utf8ws_pkg.sv */
package utf8ws_pkg;

  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 4;
  localparam int CP_W    = 31;
  localparam int CNT_W   = 13;
  localparam int WID_W   = 14;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_BYTE = 2'd1,
    OP_END  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    REG_BOX_STYLE  = 2'd0,
    REG_SUB_START  = 2'd1,
    REG_SUB_LENGTH = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    Q_LOAD = 2'd0,
    Q_BYTE = 2'd1,
    Q_END  = 2'd2
  } q_kind_t;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_SUMMARY = 1'b1
  } out_kind_t;

  typedef struct packed {
    logic             box_style;
    logic [CNT_W-1:0] sub_start;
    logic [CNT_W-1:0] sub_length;
  } cfg_t;

  // One queued work unit. For a range load, cp carries the low bound.
  typedef struct packed {
    q_kind_t           kind;
    logic              fwd;
    logic              finish;
    logic [BYTE_W-1:0] byte_val;
    logic [CP_W-1:0]   cp;
    logic [IDX_W-1:0]  idx;
    logic [CP_W-1:0]   hi;
    logic [CNT_W-1:0]  char_count;
    logic [CNT_W-1:0]  subc;
  } q_entry_t;

endpackage

/* hw/rtl/utf8ws_if.sv */
interface utf8ws_in_if import utf8ws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] byte_value;
  logic [IDX_W-1:0]  range_index;
  logic [CP_W-1:0]   range_low;
  logic [CP_W-1:0]   range_high;

  modport source (output valid, opcode, byte_value, range_index, range_low, range_high,
                  input ready);
  modport sink   (input valid, opcode, byte_value, range_index, range_low, range_high,
                  output ready);
endinterface

interface utf8ws_out_if import utf8ws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] out_byte;
  logic [CNT_W-1:0]  char_count;
  logic [WID_W-1:0]  display_width;
  logic [CNT_W-1:0]  substring_chars;

  modport source (output valid, kind, out_byte, char_count, display_width, substring_chars,
                  input ready);
  modport sink   (input valid, kind, out_byte, char_count, display_width, substring_chars,
                  output ready);
endinterface

/* hw/rtl/utf8ws_fifo.sv */
module utf8ws_fifo import utf8ws_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wdata,
  output logic     full,
  input  logic     pop,
  output q_entry_t rdata,
  output logic     empty
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full  = (count_r == (PTR_W+1)'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

/* hw/rtl/utf8ws_front.sv */
module utf8ws_front import utf8ws_pkg::*; #(
  parameter int MAX_STRING_CHARS = 4096
) (
  input  logic     clk,
  input  logic     rst_n,
  utf8ws_in_if.sink in_if,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     q_push,
  output q_entry_t q_entry
);

  localparam int CW = $clog2(MAX_STRING_CHARS + 1);
  localparam int SW = ((CW > CNT_W + 1) ? CW : CNT_W + 1) + 1;

  logic [2:0]      br_r, br_nxt;
  logic [CP_W-1:0] cp_r, cp_nxt;
  logic [CW-1:0]   seen_r, seen_nxt;
  logic [CW-1:0]   copied_r, copied_nxt;
  logic            copying_r, copying_nxt;

  logic            acc;
  logic [2:0]      len;
  logic            room;
  logic [CW-1:0]   seen_inc;
  logic            copy_new;
  logic [SW-1:0]   idx_w, start_w, end_w;

  function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
    logic [2:0] n;
    if (!b[7])                      n = 3'd1;
    else if ((b & 8'hFC) == 8'hFC)  n = 3'd6;
    else if ((b & 8'hF8) == 8'hF8)  n = 3'd5;
    else if ((b & 8'hF0) == 8'hF0)  n = 3'd4;
    else if ((b & 8'hE0) == 8'hE0)  n = 3'd3;
    else if ((b & 8'hC0) == 8'hC0)  n = 3'd2;
    else                            n = 3'd0;  // stray continuation
    return n;
  endfunction

  assign in_if.ready = !q_full;
  assign acc = in_if.valid && in_if.ready;

  // Start-of-character bookkeeping
  assign len      = lead_len(in_if.byte_value);
  assign room     = (seen_r < CW'(MAX_STRING_CHARS));
  assign seen_inc = room ? seen_r + 1'b1 : seen_r;
  assign idx_w    = SW'(seen_inc);
  assign start_w  = SW'(cfg.sub_start);
  assign end_w    = SW'(cfg.sub_start) + SW'(cfg.sub_length);
  assign copy_new = room && (cfg.sub_start != '0) && (cfg.sub_length != '0) &&
                    (idx_w >= start_w) && (idx_w < end_w);

  always_comb begin
    br_nxt      = br_r;
    cp_nxt      = cp_r;
    seen_nxt    = seen_r;
    copied_nxt  = copied_r;
    copying_nxt = copying_r;
    q_push      = 1'b0;
    q_entry     = '0;
    case (opcode_t'(in_if.opcode))
      OP_LOAD: begin
        q_push        = acc;
        q_entry.kind  = Q_LOAD;
        q_entry.idx   = in_if.range_index;
        q_entry.cp    = in_if.range_low;
        q_entry.hi    = in_if.range_high;
      end
      OP_BYTE: begin
        q_push           = acc;
        q_entry.kind     = Q_BYTE;
        q_entry.byte_val = in_if.byte_value;
        if (br_r == '0) begin
          cp_nxt      = CP_W'(in_if.byte_value & (8'hFF >> len));
          br_nxt      = (len == '0) ? 3'd0 : len - 1'b1;
          seen_nxt    = seen_inc;
          copying_nxt = copy_new;
          if (copy_new) copied_nxt = copied_r + 1'b1;
        end else begin
          cp_nxt = {cp_r[CP_W-7:0], in_if.byte_value[5:0]};
          br_nxt = br_r - 1'b1;
        end
        q_entry.cp     = cp_nxt;
        q_entry.finish = (br_nxt == '0);
        q_entry.fwd    = copying_nxt;
      end
      OP_END: begin
        q_push             = acc;
        q_entry.kind       = Q_END;
        q_entry.cp         = cp_r;
        q_entry.finish     = (br_r != '0);  // truncated last character
        q_entry.char_count = CNT_W'(seen_r);
        if (cfg.sub_start == '0 || cfg.sub_length == '0)
          q_entry.subc = '0;
        else if (SW'(cfg.sub_start) > SW'(seen_r))
          q_entry.subc = CNT_W'(seen_r);
        else
          q_entry.subc = CNT_W'(copied_r);
        br_nxt      = '0;
        cp_nxt      = '0;
        seen_nxt    = '0;
        copied_nxt  = '0;
        copying_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      br_r      <= '0;
      cp_r      <= '0;
      seen_r    <= '0;
      copied_r  <= '0;
      copying_r <= 1'b0;
    end else if (acc) begin
      br_r      <= br_nxt;
      cp_r      <= cp_nxt;
      seen_r    <= seen_nxt;
      copied_r  <= copied_nxt;
      copying_r <= copying_nxt;
    end
  end

endmodule

/* hw/rtl/utf8ws_back.sv */
module utf8ws_back import utf8ws_pkg::*; #(
  parameter int MAX_STRING_CHARS = 4096,
  parameter int RANGE_COUNT      = 9
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       box_style,
  input  logic       q_empty,
  input  q_entry_t   q_head,
  output logic       q_pop,
  utf8ws_out_if.source out_if
);

  localparam int WW  = $clog2(2 * MAX_STRING_CHARS + 1);
  localparam logic [WW:0] CAP = (WW+1)'(2 * MAX_STRING_CHARS);

  logic [CP_W-1:0]  low_r  [RANGE_COUNT];
  logic [CP_W-1:0]  high_r [RANGE_COUNT];
  logic [WW-1:0]    ws_r, ws_nxt;
  logic             out_v_r, out_v_nxt;

  logic             kind_r;
  logic [BYTE_W-1:0] byte_r;
  logic [CNT_W-1:0] cnt_r, subc_r;
  logic [WID_W-1:0] wid_r;

  logic [RANGE_COUNT-1:0] hit;
  logic             wide;
  logic [WW:0]      sum;
  logic [WW-1:0]    ws_add;
  logic             emit;
  logic             tbl_we;

  assign q_pop = !q_empty && (!out_v_r || out_if.ready);

  always_comb begin
    for (int i = 0; i < RANGE_COUNT; i++)
      hit[i] = (q_head.cp >= low_r[i]) && (q_head.cp <= high_r[i]);
  end

  // Without box style a hit in entry 0 forces narrow
  assign wide   = box_style ? (|hit) : (!hit[0] && (|hit));
  assign sum    = (WW+1)'(ws_r) + (wide ? (WW+1)'(2) : (WW+1)'(1));
  assign ws_add = (sum > CAP) ? WW'(CAP) : WW'(sum);

  assign tbl_we = q_pop && (q_head.kind == Q_LOAD) &&
                  ({1'b0, q_head.idx} < (IDX_W+1)'(RANGE_COUNT));

  always_comb begin
    ws_nxt = ws_r;
    emit   = 1'b0;
    case (q_head.kind)
      Q_BYTE: begin
        if (q_head.finish) ws_nxt = ws_add;
        emit = q_head.fwd;
      end
      Q_END: begin
        ws_nxt = '0;
        emit   = 1'b1;
      end
      default: ;
    endcase
    if (!q_pop) begin
      ws_nxt = ws_r;
      emit   = 1'b0;
    end
    if (emit)              out_v_nxt = 1'b1;
    else if (out_if.ready) out_v_nxt = 1'b0;
    else                   out_v_nxt = out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r    <= '0;
      out_v_r <= 1'b0;
      for (int i = 0; i < RANGE_COUNT; i++) begin
        low_r[i]  <= '1;
        high_r[i] <= '0;
      end
    end else begin
      ws_r    <= ws_nxt;
      out_v_r <= out_v_nxt;
      for (int i = 0; i < RANGE_COUNT; i++) begin
        if (tbl_we && (q_head.idx == IDX_W'(i))) begin
          low_r[i]  <= q_head.cp;
          high_r[i] <= q_head.hi;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (q_head.kind == Q_END) begin
        kind_r <= KIND_SUMMARY;
        byte_r <= '0;
        cnt_r  <= q_head.char_count;
        wid_r  <= WID_W'(q_head.finish ? ws_add : ws_r);
        subc_r <= q_head.subc;
      end else begin
        kind_r <= KIND_BYTE;
        byte_r <= q_head.byte_val;
        cnt_r  <= '0;
        wid_r  <= '0;
        subc_r <= '0;
      end
    end
  end

  assign out_if.valid           = out_v_r;
  assign out_if.kind            = kind_r;
  assign out_if.out_byte        = byte_r;
  assign out_if.char_count      = cnt_r;
  assign out_if.display_width   = wid_r;
  assign out_if.substring_chars = subc_r;

endmodule

/* hw/rtl/utf8_width_and_substring.sv */
// A result item is written into the queue when accepted and then into the output register,
// where it is held while the sink stalls.
// Throughput: 1 item per cycle while the queue has room; a 4-entry queue sits between
// the decoder and the range compare / width accumulator. A stalled result blocks the
// back, and input ready drops once the queue holds 4 items.
// Reset (synchronous, rst_n low): range table emptied, counters, registers, queue cleared.
module utf8_width_and_substring import utf8ws_pkg::*; #(
  parameter int MAX_STRING_CHARS = 4096,
  parameter int RANGE_COUNT      = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  utf8ws_in_if.sink          in_if,
  utf8ws_out_if.source       out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t     cfg_r;
  logic     q_push, q_pop, q_full, q_empty;
  q_entry_t q_wdata, q_rdata;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_BOX_STYLE:  cfg_r.box_style  <= pwdata[0];
        REG_SUB_START:  cfg_r.sub_start  <= pwdata[CNT_W-1:0];
        REG_SUB_LENGTH: cfg_r.sub_length <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BOX_STYLE:  prdata = PDATA_W'(cfg_r.box_style);
      REG_SUB_START:  prdata = PDATA_W'(cfg_r.sub_start);
      REG_SUB_LENGTH: prdata = PDATA_W'(cfg_r.sub_length);
      default:        prdata = '0;
    endcase
  end

  utf8ws_front #(
    .MAX_STRING_CHARS(MAX_STRING_CHARS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_wdata)
  );

  utf8ws_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  utf8ws_back #(
    .MAX_STRING_CHARS(MAX_STRING_CHARS),
    .RANGE_COUNT     (RANGE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .box_style (cfg_r.box_style),
    .q_empty   (q_empty),
    .q_head    (q_rdata),
    .q_pop     (q_pop),
    .out_if    (out_if)
  );

endmodule

/* hw/rtl/utf8ws_checker.sv */
module utf8ws_checker import utf8ws_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              kind,
  input logic [BYTE_W-1:0] out_byte,
  input logic [CNT_W-1:0]  char_count,
  input logic [WID_W-1:0]  display_width,
  input logic [CNT_W-1:0]  substring_chars
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte))
    else $error("result item dropped or changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_BYTE |->
      char_count == '0 && display_width == '0 && substring_chars == '0)
    else $error("forwarded byte carries summary counts");

  a_summary_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_SUMMARY |->
      out_byte == '0 && substring_chars <= char_count &&
      display_width >= WID_W'(char_count) &&
      display_width <= WID_W'({char_count, 1'b0}))
    else $error("summary counts inconsistent");

endmodule

bind utf8_width_and_substring utf8ws_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .kind            (out_if.kind),
  .out_byte        (out_if.out_byte),
  .char_count      (out_if.char_count),
  .display_width   (out_if.display_width),
  .substring_chars (out_if.substring_chars)
);

/* test/tb.sv */
module tb;
  import utf8ws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANGES     = 9;
  localparam int MAX_CHARS  = 4096;
  localparam int SETTLE     = 12;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD  = 400;
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] b;
    logic [IDX_W-1:0]  idx;
    logic [CP_W-1:0]   lo;
    logic [CP_W-1:0]   hi;
  } in_t;

  typedef struct packed {
    out_kind_t         kind;
    logic [BYTE_W-1:0] b;
    logic [CNT_W-1:0]  cc;
    logic [WID_W-1:0]  dw;
    logic [CNT_W-1:0]  sc;
  } out_t;

  // Tracks string decode state and the bytes/summaries the block owes us.
  class utf8_tally;
    bit box;
    int unsigned first_char, char_span;
    bit [CP_W-1:0] lo_tab [RANGES];
    bit [CP_W-1:0] hi_tab [RANGES];
    int unsigned rem, seen, cols, copied;
    bit [CP_W-1:0] acc;
    bit copy_on;
    out_t owed[$];
    int errors, sums, fwd;

    function new();
      box = 0;
      first_char = 0;
      char_span = 0;
      foreach (lo_tab[i]) begin
        lo_tab[i] = '1;
        hi_tab[i] = '0;
      end
      errors = 0;
      sums = 0;
      fwd = 0;
      wipe_string();
    endfunction

    function void wipe_string();
      rem = 0;
      acc = '0;
      seen = 0;
      cols = 0;
      copied = 0;
      copy_on = 0;
    endfunction

    function void set_reg(reg_idx_t r, int unsigned v);
      case (r)
        REG_BOX_STYLE:  box = v[0];
        REG_SUB_START:  first_char = v & 'h1FFF;
        REG_SUB_LENGTH: char_span = v & 'h1FFF;
        default: ;
      endcase
    endfunction

    function bit is_double_width(bit [CP_W-1:0] cp);
      // with box style off, entry 0 overrides every other range
      if (!box && cp >= lo_tab[0] && cp <= hi_tab[0]) return 1'b0;
      for (int i = 0; i < RANGES; i++)
        if (cp >= lo_tab[i] && cp <= hi_tab[i]) return 1'b1;
      return 1'b0;
    endfunction

    function int unsigned lead_len(bit [7:0] b);
      if (!b[7]) return 1;
      if (b[7:2] == 6'b111111) return 6;
      if (b[7:3] == 5'b11111) return 5;
      if (b[7:4] == 4'b1111) return 4;
      if (b[7:5] == 3'b111) return 3;
      if (b[7:6] == 2'b11) return 2;
      return 0;
    endfunction

    function void add_columns();
      cols += is_double_width(acc) ? 2 : 1;
      if (cols > 2 * MAX_CHARS) cols = 2 * MAX_CHARS;
    endfunction

    function void absorb_item(in_t it);
      int unsigned len, subc;
      bit room;
      case (it.op)
        OP_LOAD: begin
          if (it.idx < RANGES) begin
            lo_tab[it.idx] = it.lo;
            hi_tab[it.idx] = it.hi;
          end
        end
        OP_BYTE: begin
          if (rem == 0) begin
            len = lead_len(it.b);
            room = seen < MAX_CHARS;
            if (len == 0) begin
              acc = CP_W'(it.b);
              rem = 0;
            end else begin
              acc = CP_W'(it.b & (8'hFF >> len));
              rem = len - 1;
            end
            if (room) seen++;
            copy_on = room && first_char != 0 && char_span != 0 &&
                      seen >= first_char && seen < first_char + char_span;
            if (copy_on) copied++;
          end else begin
            acc = {acc[CP_W-7:0], it.b[5:0]};
            rem--;
          end
          if (rem == 0) add_columns();
          if (copy_on) owed.push_back('{KIND_BYTE, it.b, '0, '0, '0});
        end
        OP_END: begin
          if (rem != 0) add_columns();  // truncated last char
          if (first_char == 0 || char_span == 0) subc = 0;
          else if (first_char > seen) subc = seen;
          else subc = copied;
          owed.push_back('{KIND_SUMMARY, '0, CNT_W'(seen), WID_W'(cols), CNT_W'(subc)});
          wipe_string();
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, exp, act);
      end
    endfunction

    function void match_result(out_t got);
      out_t exp;
      if (owed.size() == 0) begin
        errors++;
        $error("result with nothing expected: kind %0d byte %0d", got.kind, got.b);
        return;
      end
      exp = owed.pop_front();
      if (exp.kind == KIND_SUMMARY) sums++;
      else fwd++;
      compare_field("kind", exp.kind, got.kind);
      compare_field("out_byte", exp.b, got.b);
      compare_field("char_count", exp.cc, got.cc);
      compare_field("display_width", exp.dw, got.dw);
      compare_field("substring_chars", exp.sc, got.sc);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic calm;
  logic hold_request;
  int unsigned items_sent;
  int unsigned idle_cycles;
  utf8_tally sb;

  utf8ws_in_if  in_ch();
  utf8ws_out_if out_ch();

  utf8_width_and_substring uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // result sink: random stalls, plus one long hold-off on request
  initial begin : sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind = out_kind_t'(out_ch.kind);
      got.b = out_ch.out_byte;
      got.cc = out_ch.char_count;
      got.dw = out_ch.display_width;
      got.sc = out_ch.substring_chars;
      sb.match_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic offer(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b, logic [IDX_W-1:0] idx,
                       logic [CP_W-1:0] lo, logic [CP_W-1:0] hi);
    in_t it;
    it = '{op, b, idx, lo, hi};
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.opcode <= op;
    in_ch.byte_value <= b;
    in_ch.range_index <= idx;
    in_ch.range_low <= lo;
    in_ch.range_high <= hi;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.absorb_item(it);
    if (op != OP_UNDEF) items_sent++;
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] b);
    offer(OP_BYTE, b, IDX_W'($urandom), CP_W'($urandom), CP_W'($urandom));
  endtask

  task automatic end_string();
    offer(OP_END, BYTE_W'($urandom), IDX_W'($urandom), CP_W'($urandom), CP_W'($urandom));
  endtask

  task automatic junk_item();
    offer(OP_UNDEF, BYTE_W'($urandom), IDX_W'($urandom), CP_W'($urandom), CP_W'($urandom));
  endtask

  task automatic load_range(logic [IDX_W-1:0] idx, logic [CP_W-1:0] lo, logic [CP_W-1:0] hi);
    offer(OP_LOAD, BYTE_W'($urandom), idx, lo, hi);
  endtask

  // wait until every owed result is out, then give the queue time to empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t r, int unsigned v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(r));
    pwdata <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(r, v);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int unsigned pick_count();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return MAX_CHARS;
      2: return $urandom_range(0, MAX_CHARS);
      default: return $urandom_range(1, 10);
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 1;
    if (r < 60) return 2;
    if (r < 85) return 3;
    if (r < 90) return 4;
    if (r < 95) return 5;
    return 6;
  endfunction

  // lead byte of a len-byte char, then keep-1 continuations (keep < len truncates)
  task automatic send_char(int len, int keep);
    logic [7:0] b;
    b = 8'($urandom);
    case (len)
      1: b[7] = 1'b0;
      2: b[7:5] = 3'b110;
      3: b[7:4] = 4'b1110;
      4: b[7:3] = 5'b11110;
      5: b[7:2] = 6'b111110;
      default: b[7:2] = 6'b111111;
    endcase
    send_byte(b);
    for (int k = 1; k < keep; k++) begin
      b = 8'($urandom);
      if ($urandom_range(0, 19) != 0) b[7:6] = 2'b10;
      send_byte(b);
    end
  endtask

  task automatic random_string();
    int n, len, roll;
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
    for (int c = 0; c < n; c++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        send_byte(8'($urandom_range('h80, 'hBF)));
      end else if (roll < 6) begin
        junk_item();
      end else begin
        len = pick_len();
        if (c == n - 1 && $urandom_range(0, 5) == 0)
          send_char(len, $urandom_range(1, len));
        else
          send_char(len, len);
      end
    end
    end_string();
  endtask

  task automatic load_random_range();
    logic [IDX_W-1:0] idx;
    logic [CP_W-1:0] lo, hi;
    if ($urandom_range(0, 4) == 0) idx = IDX_W'($urandom_range(0, 15));
    else idx = IDX_W'($urandom_range(0, RANGES - 1));
    case ($urandom_range(0, 3))
      0: begin
        lo = CP_W'($urandom);
        hi = CP_W'($urandom);
      end
      1: begin
        lo = CP_W'($urandom_range(0, 'hFFFF));
        hi = lo + CP_W'($urandom_range(0, 'h3000));
      end
      2: begin
        lo = CP_W'($urandom_range(0, 'h7F));
        hi = lo + CP_W'($urandom_range(0, 'h40));
      end
      default: begin
        lo = '1;
        hi = '0;
      end
    endcase
    load_range(idx, lo, hi);
  endtask

  task automatic random_setup();
    drain();
    reg_write(REG_BOX_STYLE, $urandom_range(0, 1));
    reg_write(REG_SUB_START, pick_count());
    reg_write(REG_SUB_LENGTH, pick_count());
  endtask

  initial begin : stimulus
    int unsigned goal, calm_from;
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.byte_value = '0;
    in_ch.range_index = '0;
    in_ch.range_low = '0;
    in_ch.range_high = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    hold_request = 1'b0;
    items_sent = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: an empty string, then one string touching each odd corner of the decoder
    reg_write(REG_BOX_STYLE, 1);
    reg_write(REG_SUB_START, 2);
    reg_write(REG_SUB_LENGTH, 3);
    load_range(0, 31'h41, 31'h41);
    load_range(RANGES - 1, 31'h4E00, 31'h9FFF);
    load_range(4'd9, 31'h0, 31'h7FFF_FFFF);           // index past table: dropped
    load_range(4'hF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    end_string();                                     // empty string
    send_byte(8'h41);                                 // wide through entry 0
    send_byte(8'hE4);
    send_byte(8'hB8);
    send_byte(8'h80);                                 // U+4E00
    send_byte(8'h80);                                 // stray continuation
    send_byte(8'h00);
    junk_item();
    drain();
    reg_write(REG_BOX_STYLE, 0);                      // mid-string change
    send_byte(8'h41);
    send_byte(8'hFF);                                 // six-byte lead, any tail bytes
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h3F);
    send_byte(8'hC0);
    send_byte(8'hF0);                                 // truncated at end
    send_byte(8'h9F);
    end_string();

    // copy everything while the sink holds off, so the block backs up
    drain();
    reg_write(REG_SUB_START, 1);
    reg_write(REG_SUB_LENGTH, MAX_CHARS);
    hold_request <= 1'b1;
    repeat (80) send_byte(8'($urandom_range(0, 'h7F)));
    end_string();

    goal = items_sent + 1400;
    calm_from = items_sent + 600;
    while (items_sent < goal) begin
      calm <= (items_sent >= calm_from && items_sent < calm_from + 250);
      if ($urandom_range(0, 5) == 0) random_setup();
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) load_random_range();
      random_string();
    end

    drain();
    $display("covered %0d items: %0d string summaries, %0d substring bytes checked",
             items_sent, sb.sums, sb.fwd);
    $display("range loads, stray and truncated chars, and a long sink stall included");
    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
